// File: src/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; clock aclk and reset aresetn are taken from the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/agr_pkg.sv
// types and constants for the audio gain ramp
// no dependencies
`default_nettype none

package agr_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int MAX_CHANNELS   = 8;

    localparam int GAIN_FRAC      = 36;
    localparam int MUL_FRAC       = 20;
    localparam int GAIN_BITS      = 40;
    localparam int DIFF_BITS      = GAIN_BITS + 1;
    localparam int TARGET_BITS    = 24;
    localparam int RFPU_BITS      = 16;
    localparam int RFPU_IDX_BITS  = 4;
    localparam int CHAN_BITS      = 4;
    localparam int THR_BITS       = 10;
    localparam int FRAMES_BITS    = 20;
    localparam int POS_BITS       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_CMP_BITS    = (CHAN_BITS > POS_BITS + 1) ? CHAN_BITS : POS_BITS + 1;
    localparam int ACC_BITS       = RFPU_BITS + GAIN_BITS;
    localparam int ALU_BITS       = ACC_BITS + 1;
    localparam int CNT_BITS       = 6;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_GAIN    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAMP_FRAMES    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_THRESHOLD = 3'd3;

    localparam logic [TARGET_BITS-1:0] TARGET_RESET    = 24'd1048576;
    localparam logic [RFPU_BITS-1:0]   RFPU_RESET      = 16'd2400;
    localparam logic [CHAN_BITS-1:0]   CHANNELS_RESET  = 4'd2;
    localparam logic [THR_BITS-1:0]    THRESHOLD_RESET = 10'd21;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_ABS,
        ST_MUL,
        ST_LEN,
        ST_DIV,
        ST_SIGN,
        ST_FRAME,
        ST_PROD,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: src/audio_gain_ramp.sv
// audio gain ramp: scales interleaved samples by a linearly ramped gain
// flow: a request is taken in idle, then passes the frame, product and output steps;
//   a planning block start first runs difference, magnitude, 16 shift-add multiply
//   steps, length, 40 divide steps and sign; one sample is in flight at a time
// reset: synchronous active-low; registers return to defaults, gain and ramp to zero
// depends on agr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module audio_gain_ramp
    import agr_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  wire logic                          s_block_start,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    output logic                               m_saturated
);

    localparam int PROD_BITS = SAMPLE_BITS + TARGET_BITS;
    localparam int RND_BITS  = PROD_BITS + 1;
    localparam int SHR_BITS  = RND_BITS - MUL_FRAC;
    localparam int REM_BITS  = FRAMES_BITS;

    // configuration
    logic [TARGET_BITS-1:0] target_reg;
    logic [RFPU_BITS-1:0]   rfpu_reg;
    logic [CHAN_BITS-1:0]   chan_reg;
    logic [THR_BITS-1:0]    thr_reg;

    // sequencer and datapath state
    state_t                        state_reg, state_next;
    logic signed [GAIN_BITS-1:0]   gain_reg, gain_next;
    logic signed [GAIN_BITS-1:0]   step_reg, step_next;
    logic signed [GAIN_BITS-1:0]   ramp_end_reg, ramp_end_next;
    logic [FRAMES_BITS-1:0]        frames_reg, frames_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic                          started_reg, started_next;
    logic                          in_ramp_reg, in_ramp_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic signed [DIFF_BITS-1:0]   diff_reg, diff_next;
    logic [GAIN_BITS-1:0]          mag_reg, mag_next;
    logic [ACC_BITS-1:0]           acc_reg, acc_next;
    logic [REM_BITS-1:0]           rem_reg, rem_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic                          bypass_reg, bypass_next;
    logic                          mute_reg, mute_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg, m_sample_next;
    logic                          m_sat_reg, m_sat_next;

    // shared adder
    logic [ALU_BITS-1:0] alu_a, alu_b, alu_y;
    logic                alu_sub;

    logic signed [GAIN_BITS-1:0]   target_q36;
    logic [FRAMES_BITS-1:0]        len_w;
    logic [REM_BITS:0]             rem_sh;
    logic                          borrow;
    logic                          out_free;
    logic signed [TARGET_BITS-1:0] gain_q20;
    logic signed [DIFF_BITS-1:0]   d_unity, gain_ext, thr_pos, thr_neg;
    logic [CH_CMP_BITS-1:0]        chan_eff, pos_inc;
    logic signed [RND_BITS-1:0]    rsum;
    logic signed [SHR_BITS-1:0]    shr, smax, smin;

    assign target_q36 = {target_reg, {(GAIN_FRAC - MUL_FRAC){1'b0}}};
    assign len_w      = acc_reg[ACC_BITS-1:GAIN_FRAC];
    assign rem_sh     = {rem_reg, mag_reg[GAIN_BITS-1]};
    assign borrow     = alu_y[ALU_BITS-1];
    assign out_free   = !m_valid_reg || m_ready;
    assign gain_q20   = gain_reg[GAIN_BITS-1:GAIN_FRAC-MUL_FRAC];

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_saturated  = m_sat_reg;

    // bypass and mute windows, threshold scaled to 36 fraction bits
    assign gain_ext = {gain_reg[GAIN_BITS-1], gain_reg};
    assign d_unity  = gain_ext - (DIFF_BITS'(1) <<< GAIN_FRAC);
    assign thr_pos  = {{(DIFF_BITS - THR_BITS - GAIN_FRAC + MUL_FRAC){1'b0}}, thr_reg,
                       {(GAIN_FRAC - MUL_FRAC){1'b0}}};
    assign thr_neg  = -thr_pos;

    // effective channel count clamped to 1..MAX_CHANNELS
    always_comb begin
        if (chan_reg == '0) begin
            chan_eff = CH_CMP_BITS'(1);
        end else if (CH_CMP_BITS'(chan_reg) > CH_CMP_BITS'(MAX_CHANNELS)) begin
            chan_eff = CH_CMP_BITS'(MAX_CHANNELS);
        end else begin
            chan_eff = CH_CMP_BITS'(chan_reg);
        end
    end
    assign pos_inc = CH_CMP_BITS'(pos_reg) + CH_CMP_BITS'(1);

    // round half up, then saturate
    assign rsum = {prod_reg[PROD_BITS-1], prod_reg}
                + {{(RND_BITS - MUL_FRAC){1'b0}}, 1'b1, {(MUL_FRAC - 1){1'b0}}};
    assign shr  = rsum[RND_BITS-1:MUL_FRAC];
    assign smax = {{(SHR_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    assign smin = {{(SHR_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    // operand select for the shared adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_DIFF: begin
                alu_a   = {{(ALU_BITS - GAIN_BITS){target_q36[GAIN_BITS-1]}}, target_q36};
                alu_b   = {{(ALU_BITS - GAIN_BITS){gain_reg[GAIN_BITS-1]}}, gain_reg};
                alu_sub = 1'b1;
            end
            ST_ABS: begin
                if (diff_reg[DIFF_BITS-1]) begin
                    alu_b   = {{(ALU_BITS - DIFF_BITS){diff_reg[DIFF_BITS-1]}}, diff_reg};
                    alu_sub = 1'b1;
                end else begin
                    alu_a = {{(ALU_BITS - DIFF_BITS){1'b0}}, diff_reg};
                end
            end
            ST_MUL: begin
                alu_a = {1'b0, acc_reg[ACC_BITS-2:0], 1'b0};
                if (rfpu_reg[cnt_reg[RFPU_IDX_BITS-1:0]]) begin
                    alu_b = {{(ALU_BITS - GAIN_BITS){1'b0}}, mag_reg};
                end
            end
            ST_DIV: begin
                alu_a   = {{(ALU_BITS - REM_BITS - 1){1'b0}}, rem_sh};
                alu_b   = {{(ALU_BITS - FRAMES_BITS){1'b0}}, len_w};
                alu_sub = 1'b1;
            end
            ST_SIGN: begin
                alu_b   = {{(ALU_BITS - GAIN_BITS){1'b0}}, mag_reg};
                alu_sub = diff_reg[DIFF_BITS-1];
                if (!diff_reg[DIFF_BITS-1]) begin
                    alu_a = alu_b;
                    alu_b = '0;
                end
            end
            ST_FRAME: begin
                alu_a = {{(ALU_BITS - GAIN_BITS){gain_reg[GAIN_BITS-1]}}, gain_reg};
                alu_b = {{(ALU_BITS - GAIN_BITS){step_reg[GAIN_BITS-1]}}, step_reg};
            end
            default: begin
            end
        endcase
    end
    assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_block_start && started_reg) ? ST_DIFF : ST_FRAME;
                end
            end
            ST_DIFF: begin
                state_next = (target_q36 == gain_reg) ? ST_FRAME : ST_ABS;
            end
            ST_ABS: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (cnt_reg == '0) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                state_next = (len_w == '0) ? ST_FRAME : ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                state_next = ST_FRAME;
            end
            ST_FRAME: begin
                state_next = ST_PROD;
            end
            ST_PROD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb begin
        gain_next     = gain_reg;
        step_next     = step_reg;
        ramp_end_next = ramp_end_reg;
        frames_next   = frames_reg;
        pos_next      = pos_reg;
        started_next  = started_reg;
        in_ramp_next  = in_ramp_reg;
        sample_next   = sample_reg;
        diff_next     = diff_reg;
        mag_next      = mag_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        bypass_next   = bypass_reg;
        mute_next     = mute_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_sample_next = m_sample_reg;
        m_sat_next    = m_sat_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample_in;
                    if (s_block_start) begin
                        pos_next = '0;
                        // first block after reset jumps straight to the target
                        if (!started_reg) begin
                            started_next = 1'b1;
                            gain_next    = target_q36;
                            frames_next  = '0;
                        end
                    end
                end
            end
            ST_DIFF: begin
                diff_next = alu_y[DIFF_BITS-1:0];
                if (target_q36 == gain_reg) begin
                    frames_next = '0;
                end
            end
            ST_ABS: begin
                mag_next = alu_y[GAIN_BITS-1:0];
                acc_next = '0;
                cnt_next = CNT_BITS'(RFPU_BITS - 1);
            end
            ST_MUL: begin
                acc_next = alu_y[ACC_BITS-1:0];
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            ST_LEN: begin
                if (len_w == '0) begin
                    frames_next = '0;
                end else begin
                    rem_next = '0;
                    cnt_next = CNT_BITS'(GAIN_BITS - 1);
                end
            end
            ST_DIV: begin
                // restoring divide, quotient bits shift into mag
                rem_next = borrow ? rem_sh[REM_BITS-1:0] : alu_y[REM_BITS-1:0];
                mag_next = {mag_reg[GAIN_BITS-2:0], !borrow};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            ST_SIGN: begin
                step_next     = alu_y[GAIN_BITS-1:0];
                frames_next   = len_w;
                ramp_end_next = target_q36;
            end
            ST_FRAME: begin
                if (pos_reg == '0) begin
                    if (frames_reg != '0) begin
                        frames_next  = frames_reg - FRAMES_BITS'(1);
                        in_ramp_next = 1'b1;
                        gain_next    = (frames_reg == FRAMES_BITS'(1)) ? ramp_end_reg
                                                                       : alu_y[GAIN_BITS-1:0];
                    end else begin
                        in_ramp_next = 1'b0;
                    end
                end
            end
            ST_PROD: begin
                prod_next   = sample_reg * gain_q20;
                bypass_next = !in_ramp_reg && (d_unity < thr_pos) && (d_unity > thr_neg);
                mute_next   = !in_ramp_reg && (gain_ext < thr_pos) && (gain_ext > thr_neg);
                pos_next    = (pos_inc >= chan_eff) ? '0 : pos_inc[POS_BITS-1:0];
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (bypass_reg) begin
                        m_sample_next = sample_reg;
                        m_sat_next    = 1'b0;
                    end else if (mute_reg) begin
                        m_sample_next = '0;
                        m_sat_next    = 1'b0;
                    end else if (shr > smax) begin
                        m_sample_next = smax[SAMPLE_BITS-1:0];
                        m_sat_next    = 1'b1;
                    end else if (shr < smin) begin
                        m_sample_next = smin[SAMPLE_BITS-1:0];
                        m_sat_next    = 1'b1;
                    end else begin
                        m_sample_next = shr[SAMPLE_BITS-1:0];
                        m_sat_next    = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
            rfpu_reg   <= RFPU_RESET;
            chan_reg   <= CHANNELS_RESET;
            thr_reg    <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TARGET_GAIN:    target_reg <= cfg_data[TARGET_BITS-1:0];
                CFG_RAMP_FRAMES:    rfpu_reg   <= cfg_data[RFPU_BITS-1:0];
                CFG_CHANNEL_COUNT:  chan_reg   <= cfg_data[CHAN_BITS-1:0];
                CFG_GAIN_THRESHOLD: thr_reg    <= cfg_data[THR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gain_reg     <= '0;
            step_reg     <= '0;
            ramp_end_reg <= '0;
            frames_reg   <= '0;
            pos_reg      <= '0;
            started_reg  <= 1'b0;
            in_ramp_reg  <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gain_reg     <= gain_next;
            step_reg     <= step_next;
            ramp_end_reg <= ramp_end_next;
            frames_reg   <= frames_next;
            pos_reg      <= pos_next;
            started_reg  <= started_next;
            in_ramp_reg  <= in_ramp_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        diff_reg     <= diff_next;
        mag_reg      <= mag_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        bypass_reg   <= bypass_next;
        mute_reg     <= mute_next;
        m_sample_reg <= m_sample_next;
        m_sat_reg    <= m_sat_next;
    end

    // one request at a time
    `ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready,
        "request accepted while previous one still in flight")
    // remainder stays below the ramp length during division
    `ASSERT_IMPL(a_rem_below_len, state_reg == ST_DIV, rem_reg < len_w,
        "divider remainder not below divisor")
    // ramp frame counter only steps down by one
    `ASSERT_NEXT(a_frames_step,
        state_reg == ST_FRAME && pos_reg == '0 && frames_reg != '0,
        frames_reg == $past(frames_reg) - FRAMES_BITS'(1),
        "ramp frame counter did not step by one")
    // a new result appears only out of the output step
    `ASSERT_IMPL(a_result_from_out, $rose(m_valid), $past(state_reg == ST_OUT),
        "result appeared outside the output step")

endmodule

`default_nettype wire

// File: tb/audio_gain_ramp_tb.sv
// testbench for audio_gain_ramp: directed and random sample streams with a gain ramp checker
// depends on agr_pkg and the audio_gain_ramp rtl
`timescale 1ns / 100ps

module audio_gain_ramp_tb;
    import agr_pkg::*;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sat;
    } gain_result_t;

    // tracks register and ramp state, predicts each scaled sample
    class gain_ramp_checker;
        logic [TARGET_BITS-1:0] target;
        logic [RFPU_BITS-1:0]   frames_per_unit;
        logic [CHAN_BITS-1:0]   channels;
        logic [THR_BITS-1:0]    threshold;
        longint                 gain;
        longint                 step;
        longint                 end_gain;
        int unsigned            frames_left;
        int unsigned            position;
        bit                     started;
        bit                     ramping;
        gain_result_t           expected_samples[$];
        int                     errors;

        function new();
            target          = TARGET_RESET;
            frames_per_unit = RFPU_RESET;
            channels        = CHANNELS_RESET;
            threshold       = THRESHOLD_RESET;
            gain            = 0;
            step            = 0;
            end_gain        = 0;
            frames_left     = 0;
            position        = 0;
            started         = 0;
            ramping         = 0;
            errors          = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_TARGET_GAIN:    target          = val[TARGET_BITS-1:0];
                CFG_RAMP_FRAMES:    frames_per_unit = val[RFPU_BITS-1:0];
                CFG_CHANNEL_COUNT:  channels        = val[CHAN_BITS-1:0];
                CFG_GAIN_THRESHOLD: threshold       = val[THR_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_channels();
            if (channels == 0) return 1;
            if (channels > MAX_CHANNELS) return MAX_CHANNELS;
            return channels;
        endfunction

        function longint mag_of(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint target_gain_q36();
            longint t;
            t = longint'(signed'(target));
            return t * (longint'(1) <<< (GAIN_FRAC - MUL_FRAC));
        endfunction

        function void plan_ramp();
            longint                t;
            longint                diff;
            longint unsigned       mag;
            longint unsigned       len;
            longint unsigned       quot;
            t = target_gain_q36();
            if (!started) begin
                // first block after reset jumps straight to the target
                started     = 1;
                gain        = t;
                frames_left = 0;
                return;
            end
            if (gain == t) begin
                frames_left = 0;
                return;
            end
            diff = t - gain;
            mag  = mag_of(diff);
            len  = frames_per_unit;
            len  = (len * mag) >> GAIN_FRAC;
            if (len == 0) begin
                frames_left = 0;
                return;
            end
            if (len > 64'hFFFFF) len = 64'hFFFFF;
            quot        = mag / len;
            step        = (diff < 0) ? -quot : quot;
            frames_left = len;
            end_gain    = t;
        endfunction

        function void note_request(logic signed [SAMPLE_BITS-1:0] smp, logic bs);
            longint       s;
            longint       g;
            longint       r;
            longint       thr;
            longint       smax;
            longint       smin;
            gain_result_t res;
            s    = smp;
            smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
            smin = -smax - 1;
            if (bs) begin
                position = 0;
                plan_ramp();
            end
            if (position == 0) begin
                if (frames_left > 0) begin
                    frames_left--;
                    ramping = 1;
                    if (frames_left == 0) gain = end_gain;
                    else gain = gain + step;
                end else begin
                    ramping = 0;
                end
            end
            thr     = threshold;
            thr     = thr * (longint'(1) <<< (GAIN_FRAC - MUL_FRAC));
            res.sat = 0;
            if (!ramping && mag_of(gain - (longint'(1) <<< GAIN_FRAC)) < thr) begin
                r = s;
            end else if (!ramping && mag_of(gain) < thr) begin
                r = 0;
            end else begin
                g = gain >>> (GAIN_FRAC - MUL_FRAC);
                r = (s * g + (longint'(1) <<< (MUL_FRAC - 1))) >>> MUL_FRAC;
                if (r > smax) begin
                    r       = smax;
                    res.sat = 1;
                end else if (r < smin) begin
                    r       = smin;
                    res.sat = 1;
                end
            end
            position++;
            if (position >= eff_channels()) position = 0;
            res.sample = r[SAMPLE_BITS-1:0];
            expected_samples.push_back(res);
        endfunction

        function void check_result(logic signed [SAMPLE_BITS-1:0] got_sample, logic got_sat);
            gain_result_t want;
            if (expected_samples.size() == 0) begin
                $error("result %0d with no request waiting", got_sample);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got_sample !== want.sample) begin
                $error("sample_out: expected %0d, got %0d", want.sample, got_sample);
                errors++;
            end
            if (got_sat !== want.sat) begin
                $error("saturated: expected %0d, got %0d", want.sat, got_sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_in;
    logic                          s_block_start;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_sample_out;
    logic                          m_saturated;

    gain_ramp_checker board;
    int                tx_idle_pct;
    int                rx_idle_pct;
    bit                hold_request;

    audio_gain_ramp uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .s_block_start (s_block_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .m_saturated   (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stall bursts and one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) board.check_result(m_sample_out, m_saturated);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 0;
                stall_left   = 300;
                m_ready <= 1'b0;
            end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(0, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_config(input logic [TARGET_BITS-1:0] tgt, input logic [RFPU_BITS-1:0] rfpu,
                                input logic [CHAN_BITS-1:0] chans, input logic [THR_BITS-1:0] thr);
        write_reg(CFG_TARGET_GAIN, CFG_DATA_BITS'(tgt));
        write_reg(CFG_RAMP_FRAMES, CFG_DATA_BITS'(rfpu));
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_BITS'(chans));
        write_reg(CFG_GAIN_THRESHOLD, CFG_DATA_BITS'(thr));
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input logic signed [SAMPLE_BITS-1:0] smp, input logic bs);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample_in   <= smp;
        s_block_start <= bs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(smp, bs);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: return SAMPLE_BITS'($urandom_range(0, 255) - 128);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [TARGET_BITS-1:0] pick_target();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return TARGET_RESET;
            // near unity or near zero, around the bypass and mute windows
            2: return TARGET_RESET + TARGET_BITS'($urandom_range(0, 2200)) - 24'd1100;
            3: return TARGET_BITS'($urandom_range(0, 2200) - 1100);
            4: return 24'h800000;
            5: return 24'h7FFFFF;
            6: return TARGET_BITS'($urandom_range(0, 2 * 1048576) - 1048576);
            default: return TARGET_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [RFPU_BITS-1:0] pick_rfpu();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return RFPU_BITS'($urandom_range(13, 300));
            default: return RFPU_BITS'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [CHAN_BITS-1:0] pick_channels();
        if ($urandom_range(0, 3) == 0) return CHAN_BITS'($urandom_range(0, 15));
        return CHAN_BITS'($urandom_range(1, 4));
    endfunction

    function automatic logic [THR_BITS-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1023;
            default: return THR_BITS'($urandom());
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 40;
        endcase
    endfunction

    // frames of interleaved samples; a few block marks are dropped or misplaced
    task automatic run_blocks(input int n_items, input int hold_at);
        int count;
        int frames;
        int len;
        logic bs;
        count = 0;
        while (count < n_items) begin
            frames = $urandom_range(1, 6);
            len    = frames * board.eff_channels();
            for (int k = 0; k < len && count < n_items; k++) begin
                bs = (k == 0);
                if ($urandom_range(0, 29) == 0) bs = ~bs;
                send_request(rand_sample(), bs);
                count++;
                if (count == hold_at) hold_request = 1;
            end
        end
    endtask

    initial begin
        int drain;
        board         = new();
        hold_request  = 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_sample_in   <= '0;
        s_block_start <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // before the first block start the gain is still zero: muted
        send_request(24'sh7FFFFF, 1'b0);
        send_request(-24'sh800000, 1'b0);
        // first block jumps to unity: bypass
        send_request(24'sh7FFFFF, 1'b1);
        send_request(-24'sh800000, 1'b0);
        send_request(24'sd1, 1'b0);
        send_request(-24'sd1, 1'b0);

        // short ramp down to -8 over three-channel frames, cut by a mid-frame block start
        wait_idle();
        apply_config(24'h800000, 16'd1, 4'd3, 10'd0);
        send_request(24'sh7FFFFF, 1'b1);
        send_request(-24'sh800000, 1'b0);
        send_request(24'sd12345, 1'b0);
        send_request(-24'sd1, 1'b0);
        send_request(24'sh7FFFFF, 1'b1);
        send_request(24'sh400000, 1'b0);
        send_request(-24'sd77, 1'b0);

        // zero-length ramp keeps the gain; channel count zero acts as one
        wait_idle();
        apply_config(24'h7FFFFF, 16'd0, 4'd0, 10'd1023);
        send_request(24'sh7FFFFF, 1'b1);
        send_request(-24'sh800000, 1'b0);
        send_request(24'sd3, 1'b0);

        // long ramp toward zero, left pending when the target changes
        wait_idle();
        apply_config(24'h000000, 16'hFFFF, 4'd15, 10'd21);
        send_request(24'sh123456, 1'b1);
        send_request(-24'sh654321, 1'b0);
        send_request(24'sh7FFFFF, 1'b0);
        send_request(-24'sh000100, 1'b0);

        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            apply_config(pick_target(), pick_rfpu(), pick_channels(), pick_threshold());
            tx_idle_pct = (ph >= 10) ? 0 : pick_idle();
            rx_idle_pct = (ph >= 10) ? 0 : pick_idle();
            run_blocks(125, (ph == 3) ? 40 : -1);
        end
        s_valid <= 1'b0;

        drain = 0;
        while (board.pending() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        if (board.pending() != 0) begin
            $display("Mismatches found");
        end else begin
            repeat (70) @(posedge aclk);
            if (board.errors == 0) begin
                $display("No mismatches found");
            end else begin
                $display("Mismatches found");
            end
        end
        $finish;
    end

endmodule
